// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when built for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LRAST_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("lrast assertion failed");
`define LRAST_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("lrast assertion failed");
`else
`define LRAST_ASSERT(lbl, clk, rst_n, prop)
`define LRAST_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hw/rtl/lrast_pkg.sv
// ---------------------------------------------------------------------------
// lrast_pkg
// shared constants, codes and command/status types of the lazy sum tree
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lrast_pkg;

	localparam int LEAVES  = 1024;
	localparam int NODES   = 2 * LEAVES;
	localparam int LEAF_W  = $clog2(LEAVES);
	localparam int NODE_W  = $clog2(NODES);
	localparam int DEPTH_W = $clog2(LEAF_W + 1);
	localparam int IDX_W   = 10;
	localparam int VAL_W   = 32;
	localparam int SUM_W   = 64;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_BUILD = 2'd1,
		REQ_ADD   = 2'd2,
		REQ_SUM   = 2'd3
	} req_kind_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_WRITE,
		ST_BLD_RD0,
		ST_BLD_RD1,
		ST_BLD_WR,
		ST_VIS_RD,
		ST_VIS_APPLY,
		ST_VIS_LEFT,
		ST_VIS_RIGHT,
		ST_ROUTE,
		ST_UP,
		ST_POST0,
		ST_POST1,
		ST_POST2,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RS_NODE,
		RS_LEFT,
		RS_RIGHT
	} rd_sel_t;

	typedef enum logic [1:0] {
		SW_CLEAR,
		SW_LEAF,
		SW_APPLY,
		SW_PAIR
	} sum_wsel_t;

	typedef enum logic [1:0] {
		PW_CLEAR,
		PW_NODE,
		PW_LEFT,
		PW_RIGHT
	} pend_wsel_t;

	typedef enum logic [2:0] {
		NU_HOLD,
		NU_ROOT,
		NU_BUILD,
		NU_DESCEND,
		NU_SIBLING,
		NU_ASCEND,
		NU_DEC
	} node_op_t;

	typedef struct packed {
		logic               [1:0] req_type;
		logic         [IDX_W-1:0] range_low;
		logic         [IDX_W-1:0] range_high;
		logic signed  [VAL_W-1:0] leaf_value;
		logic signed  [VAL_W-1:0] add_value;
	} req_word_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum_value;
		logic                    sum_valid;
	} rsp_word_t;

	typedef struct packed {
		logic       load;
		logic       clr_inc;
		logic       sum_we;
		sum_wsel_t  sum_wsel;
		logic       pend_we;
		pend_wsel_t pend_wsel;
		rd_sel_t    sum_rsel;
		rd_sel_t    pend_rsel;
		node_op_t   node_op;
		logic       apply;
		logic       save_b;
		logic       acc_add;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic      clear_last;
		req_kind_t kind;
		logic      empty;
		logic      is_leaf;
		logic      disjoint;
		logic      covered;
		logic      t_nonzero;
		logic      is_root;
		logic      is_even;
		logic      out_free;
	} status_t;

endpackage
`default_nettype wire

// File: hw/rtl/lrast_req_if.sv
// ---------------------------------------------------------------------------
// lrast_req_if
// request channel: valid/ready handshake with one request word
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface lrast_req_if;
	logic                                valid;
	logic                                ready;
	logic                          [1:0] req_type;
	logic        [lrast_pkg::IDX_W-1:0] range_low;
	logic        [lrast_pkg::IDX_W-1:0] range_high;
	logic signed [lrast_pkg::VAL_W-1:0] leaf_value;
	logic signed [lrast_pkg::VAL_W-1:0] add_value;

	modport source (
		output valid, req_type, range_low, range_high, leaf_value, add_value,
		input  ready
	);
	modport sink (
		input  valid, req_type, range_low, range_high, leaf_value, add_value,
		output ready
	);
endinterface
`default_nettype wire

// File: hw/rtl/lrast_rsp_if.sv
// ---------------------------------------------------------------------------
// lrast_rsp_if
// response channel: valid/ready handshake with one result word
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface lrast_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [lrast_pkg::SUM_W-1:0] sum_value;
	logic                                sum_valid;

	modport source (
		output valid, sum_value, sum_valid,
		input  ready
	);
	modport sink (
		input  valid, sum_value, sum_valid,
		output ready
	);
endinterface
`default_nettype wire

// File: hw/rtl/lrast_dp.sv
// ---------------------------------------------------------------------------
// lrast_dp
// datapath: node sum and pending add memories, node walker, accumulator and
// result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lrast_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lrast_pkg::cmd_t      cmd,
	output lrast_pkg::status_t        stat,
	input  wire lrast_pkg::req_word_t req_w,
	input  wire logic                 rsp_ready,
	output logic                      rsp_valid,
	output lrast_pkg::rsp_word_t      rsp_w
);

	logic [lrast_pkg::SUM_W-1:0] sum_mem  [lrast_pkg::NODES];
	logic [lrast_pkg::SUM_W-1:0] pend_mem [lrast_pkg::NODES];

	logic [lrast_pkg::SUM_W-1:0] sum_rd_q, pend_rd_q;
	logic [lrast_pkg::NODE_W-1:0] sum_ra, pend_ra, sum_wa, pend_wa;
	logic [lrast_pkg::SUM_W-1:0] sum_wd, pend_wd;

	lrast_pkg::req_kind_t        kind_q;
	logic [lrast_pkg::IDX_W-1:0] lo_q, hi_q;
	logic [lrast_pkg::VAL_W-1:0] leaf_q, add_q;

	logic [lrast_pkg::NODE_W-1:0]  n_q, clr_q;
	logic [lrast_pkg::DEPTH_W-1:0] d_q;
	logic [lrast_pkg::SUM_W-1:0]   t_q, snew_q, b_q, acc_q;

	logic                          out_v_q;
	logic [lrast_pkg::SUM_W-1:0]   out_sum_q;
	logic                          out_sv_q;

	logic [lrast_pkg::NODE_W-1:0]  left_n, right_n, leaf_n;
	logic [lrast_pkg::DEPTH_W-1:0] shamt;
	logic [lrast_pkg::NODE_W-1:0]  span_mask, off, s_full;
	logic [lrast_pkg::LEAF_W-1:0]  s_idx, e_idx;
	logic [lrast_pkg::SUM_W-1:0]   add_ext, leaf_ext, t_val, sum_new;
	logic                          node_covered;

	// node geometry
	assign left_n   = {n_q[lrast_pkg::NODE_W-2:0], 1'b0};
	assign right_n  = {n_q[lrast_pkg::NODE_W-2:0], 1'b1};
	assign leaf_n   = {1'b1, lo_q[lrast_pkg::LEAF_W-1:0]};
	assign shamt    = lrast_pkg::DEPTH_W'(lrast_pkg::LEAF_W) - d_q;
	assign span_mask = (lrast_pkg::NODE_W'(1) << shamt) - lrast_pkg::NODE_W'(1);
	assign off      = n_q & ((lrast_pkg::NODE_W'(1) << d_q) - lrast_pkg::NODE_W'(1));
	assign s_full   = off << shamt;
	assign s_idx    = s_full[lrast_pkg::LEAF_W-1:0];
	assign e_idx    = s_idx | span_mask[lrast_pkg::LEAF_W-1:0];
	assign node_covered = (lo_q <= s_idx) && (e_idx <= hi_q);

	assign add_ext  = {{(lrast_pkg::SUM_W-lrast_pkg::VAL_W){add_q[lrast_pkg::VAL_W-1]}}, add_q};
	assign leaf_ext = {{(lrast_pkg::SUM_W-lrast_pkg::VAL_W){leaf_q[lrast_pkg::VAL_W-1]}},
		leaf_q};

	// pending add of this node, plus the new add when the node is covered
	always_comb begin
		t_val = pend_rd_q;
		if (kind_q == lrast_pkg::REQ_ADD && node_covered) begin
			t_val = pend_rd_q + add_ext;
		end
		sum_new = sum_rd_q + (t_val << shamt);
	end

	always_comb begin
		stat.clear_last = (clr_q == lrast_pkg::NODE_W'(lrast_pkg::NODES - 1));
		stat.kind       = kind_q;
		stat.empty      = (lo_q > hi_q);
		stat.is_leaf    = (d_q == lrast_pkg::DEPTH_W'(lrast_pkg::LEAF_W));
		stat.disjoint   = (hi_q < s_idx) || (e_idx < lo_q);
		stat.covered    = node_covered;
		stat.t_nonzero  = (t_val != '0);
		stat.is_root    = (n_q == lrast_pkg::NODE_W'(1));
		stat.is_even    = ~n_q[0];
		stat.out_free   = ~out_v_q | rsp_ready;
	end

	// address and write data selection
	always_comb begin
		unique case (cmd.sum_rsel)
			lrast_pkg::RS_LEFT:  sum_ra = left_n;
			lrast_pkg::RS_RIGHT: sum_ra = right_n;
			default:             sum_ra = n_q;
		endcase
		unique case (cmd.pend_rsel)
			lrast_pkg::RS_LEFT:  pend_ra = left_n;
			lrast_pkg::RS_RIGHT: pend_ra = right_n;
			default:             pend_ra = n_q;
		endcase
		unique case (cmd.sum_wsel)
			lrast_pkg::SW_CLEAR: begin
				sum_wa = clr_q;
				sum_wd = '0;
			end
			lrast_pkg::SW_LEAF: begin
				sum_wa = leaf_n;
				sum_wd = leaf_ext;
			end
			lrast_pkg::SW_APPLY: begin
				sum_wa = n_q;
				sum_wd = sum_new;
			end
			default: begin
				sum_wa = n_q;
				sum_wd = b_q + sum_rd_q;
			end
		endcase
		unique case (cmd.pend_wsel)
			lrast_pkg::PW_CLEAR: begin
				pend_wa = clr_q;
				pend_wd = '0;
			end
			lrast_pkg::PW_NODE: begin
				pend_wa = n_q;
				pend_wd = '0;
			end
			lrast_pkg::PW_LEFT: begin
				pend_wa = left_n;
				pend_wd = pend_rd_q + t_q;
			end
			default: begin
				pend_wa = right_n;
				pend_wd = pend_rd_q + t_q;
			end
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.sum_we) begin
			sum_mem[sum_wa] <= sum_wd;
		end
		sum_rd_q <= sum_mem[sum_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.pend_we) begin
			pend_mem[pend_wa] <= pend_wd;
		end
		pend_rd_q <= pend_mem[pend_ra];
	end

	// request payload and work registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= lrast_pkg::req_kind_t'(req_w.req_type);
			lo_q   <= req_w.range_low;
			hi_q   <= req_w.range_high;
			leaf_q <= req_w.leaf_value;
			add_q  <= req_w.add_value;
		end
		if (cmd.apply) begin
			t_q    <= t_val;
			snew_q <= sum_new;
		end
		if (cmd.save_b) begin
			b_q <= sum_rd_q;
		end
		if (cmd.load) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + snew_q;
		end
		if (cmd.out_load) begin
			out_sum_q <= (kind_q == lrast_pkg::REQ_SUM) ? acc_q : '0;
			out_sv_q  <= (kind_q == lrast_pkg::REQ_SUM);
		end
	end

	// node walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			d_q   <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.clr_inc) begin
				clr_q <= clr_q + lrast_pkg::NODE_W'(1);
			end
			unique case (cmd.node_op)
				lrast_pkg::NU_ROOT: begin
					n_q <= lrast_pkg::NODE_W'(1);
					d_q <= '0;
				end
				lrast_pkg::NU_BUILD: begin
					n_q <= lrast_pkg::NODE_W'(lrast_pkg::LEAVES - 1);
				end
				lrast_pkg::NU_DESCEND: begin
					n_q <= left_n;
					d_q <= d_q + lrast_pkg::DEPTH_W'(1);
				end
				lrast_pkg::NU_SIBLING: begin
					n_q <= n_q + lrast_pkg::NODE_W'(1);
				end
				lrast_pkg::NU_ASCEND: begin
					n_q <= n_q >> 1;
					d_q <= d_q - lrast_pkg::DEPTH_W'(1);
				end
				lrast_pkg::NU_DEC: begin
					n_q <= n_q - lrast_pkg::NODE_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_v_q <= 1'b1;
		end else if (rsp_ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign rsp_valid       = out_v_q;
	assign rsp_w.sum_value = out_sum_q;
	assign rsp_w.sum_valid = out_sv_q;

endmodule
`default_nettype wire

// File: hw/rtl/lrast_ctrl.sv
// ---------------------------------------------------------------------------
// lrast_ctrl
// controller: clearing pass, request dispatch and tree walk sequencing
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lrast_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire lrast_pkg::status_t stat,
	output lrast_pkg::cmd_t         cmd
);

	lrast_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrast_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			lrast_pkg::ST_CLEAR: begin
				cmd.sum_we    = 1'b1;
				cmd.sum_wsel  = lrast_pkg::SW_CLEAR;
				cmd.pend_we   = 1'b1;
				cmd.pend_wsel = lrast_pkg::PW_CLEAR;
				cmd.clr_inc   = 1'b1;
				if (stat.clear_last) begin
					state_d = lrast_pkg::ST_IDLE;
				end
			end
			lrast_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = lrast_pkg::ST_DISPATCH;
				end
			end
			lrast_pkg::ST_DISPATCH: begin
				unique case (stat.kind) inside
					lrast_pkg::REQ_WRITE: begin
						state_d = lrast_pkg::ST_WRITE;
					end
					lrast_pkg::REQ_BUILD: begin
						cmd.node_op = lrast_pkg::NU_BUILD;
						state_d     = lrast_pkg::ST_BLD_RD0;
					end
					lrast_pkg::REQ_ADD, lrast_pkg::REQ_SUM: begin
						cmd.node_op = lrast_pkg::NU_ROOT;
						state_d     = stat.empty ? lrast_pkg::ST_DONE : lrast_pkg::ST_VIS_RD;
					end
					default: begin
						state_d = lrast_pkg::ST_IDLE;
					end
				endcase
			end
			lrast_pkg::ST_WRITE: begin
				cmd.sum_we   = 1'b1;
				cmd.sum_wsel = lrast_pkg::SW_LEAF;
				state_d      = lrast_pkg::ST_DONE;
			end
			lrast_pkg::ST_BLD_RD0: begin
				cmd.sum_rsel = lrast_pkg::RS_LEFT;
				state_d      = lrast_pkg::ST_BLD_RD1;
			end
			lrast_pkg::ST_BLD_RD1: begin
				cmd.save_b   = 1'b1;
				cmd.sum_rsel = lrast_pkg::RS_RIGHT;
				state_d      = lrast_pkg::ST_BLD_WR;
			end
			lrast_pkg::ST_BLD_WR: begin
				cmd.sum_we   = 1'b1;
				cmd.sum_wsel = lrast_pkg::SW_PAIR;
				if (stat.is_root) begin
					state_d = lrast_pkg::ST_DONE;
				end else begin
					cmd.node_op = lrast_pkg::NU_DEC;
					state_d     = lrast_pkg::ST_BLD_RD0;
				end
			end
			lrast_pkg::ST_VIS_RD: begin
				cmd.sum_rsel  = lrast_pkg::RS_NODE;
				cmd.pend_rsel = lrast_pkg::RS_NODE;
				state_d       = lrast_pkg::ST_VIS_APPLY;
			end
			lrast_pkg::ST_VIS_APPLY: begin
				cmd.apply     = 1'b1;
				cmd.sum_we    = 1'b1;
				cmd.sum_wsel  = lrast_pkg::SW_APPLY;
				cmd.pend_we   = 1'b1;
				cmd.pend_wsel = lrast_pkg::PW_NODE;
				cmd.pend_rsel = lrast_pkg::RS_LEFT;
				if (stat.t_nonzero && !stat.is_leaf) begin
					state_d = lrast_pkg::ST_VIS_LEFT;
				end else begin
					state_d = lrast_pkg::ST_ROUTE;
				end
			end
			lrast_pkg::ST_VIS_LEFT: begin
				cmd.pend_we   = 1'b1;
				cmd.pend_wsel = lrast_pkg::PW_LEFT;
				cmd.pend_rsel = lrast_pkg::RS_RIGHT;
				state_d       = lrast_pkg::ST_VIS_RIGHT;
			end
			lrast_pkg::ST_VIS_RIGHT: begin
				cmd.pend_we   = 1'b1;
				cmd.pend_wsel = lrast_pkg::PW_RIGHT;
				state_d       = lrast_pkg::ST_ROUTE;
			end
			lrast_pkg::ST_ROUTE: begin
				if (!stat.disjoint && !stat.covered) begin
					cmd.node_op = lrast_pkg::NU_DESCEND;
					state_d     = lrast_pkg::ST_VIS_RD;
				end else begin
					cmd.acc_add = stat.covered && (stat.kind == lrast_pkg::REQ_SUM);
					state_d     = lrast_pkg::ST_UP;
				end
			end
			lrast_pkg::ST_UP: begin
				if (stat.is_root) begin
					state_d = lrast_pkg::ST_DONE;
				end else if (stat.is_even) begin
					cmd.node_op = lrast_pkg::NU_SIBLING;
					state_d     = lrast_pkg::ST_VIS_RD;
				end else begin
					cmd.node_op = lrast_pkg::NU_ASCEND;
					state_d     = (stat.kind == lrast_pkg::REQ_ADD) ? lrast_pkg::ST_POST0
						: lrast_pkg::ST_UP;
				end
			end
			lrast_pkg::ST_POST0: begin
				cmd.sum_rsel = lrast_pkg::RS_LEFT;
				state_d      = lrast_pkg::ST_POST1;
			end
			lrast_pkg::ST_POST1: begin
				cmd.save_b   = 1'b1;
				cmd.sum_rsel = lrast_pkg::RS_RIGHT;
				state_d      = lrast_pkg::ST_POST2;
			end
			lrast_pkg::ST_POST2: begin
				cmd.sum_we   = 1'b1;
				cmd.sum_wsel = lrast_pkg::SW_PAIR;
				state_d      = lrast_pkg::ST_UP;
			end
			lrast_pkg::ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = lrast_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lrast_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: hw/rtl/lazy_range_add_sum_tree_unit.sv
// ---------------------------------------------------------------------------
// lazy_range_add_sum_tree_unit
// lazy segment tree with range add and range sum over 64-bit wrapping sums
// ---------------------------------------------------------------------------
// Every request returns exactly one result word. After reset a clearing pass
// zeroes both node memories; no request is taken until it ends. One request
// is worked at a time by a sequencer that drives each single-write-port
// memory. A leaf write stores one leaf, a build recomputes every internal
// node from its children, and a range add or sum walks the tree from the
// root, pushing pending adds down to the children; an add also recomputes
// each partially covered node on the way up. A range touches at most about
// four nodes per level. An empty range skips the tree walk. A result waits
// in an output register until taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lazy_range_add_sum_tree_unit (
	input  wire logic    clk,
	input  wire logic    arst_n,
	lrast_req_if.sink    req,
	lrast_rsp_if.source  rsp
);

	lrast_pkg::cmd_t      cmd;
	lrast_pkg::status_t   stat;
	lrast_pkg::req_word_t req_w;
	lrast_pkg::rsp_word_t rsp_w;
	logic                 req_ready;
	logic                 rsp_valid;

	assign req_w.req_type   = req.req_type;
	assign req_w.range_low  = req.range_low;
	assign req_w.range_high = req.range_high;
	assign req_w.leaf_value = req.leaf_value;
	assign req_w.add_value  = req.add_value;

	lrast_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lrast_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_w     (req_w),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp_valid),
		.rsp_w     (rsp_w)
	);

	assign req.ready     = req_ready;
	assign rsp.valid     = rsp_valid;
	assign rsp.sum_value = rsp_w.sum_value;
	assign rsp.sum_valid = rsp_w.sum_valid;

	`LRAST_ASSERT_ALWAYS(a_no_take_in_reset, clk, !arst_n |-> !req.ready)
	`LRAST_ASSERT(a_busy_after_take, clk, arst_n, req.valid && req.ready |=> !req.ready)
	`LRAST_ASSERT(a_zero_unless_sum, clk, arst_n,
		rsp.valid && !rsp.sum_valid |-> rsp.sum_value == '0)
	`LRAST_ASSERT(a_load_into_free, clk, arst_n, cmd.out_load |-> stat.out_free)

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the lazy range add / range sum tree: a directed
// table followed by random traffic. A behavioral tree model predicts each
// result word that the table does not give, and the responses are compared
// in order under varying idle and stall pressure.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;

	localparam int N_RANDOM = 1225;

	typedef struct {
		lrast_pkg::req_kind_t              kind;
		logic [lrast_pkg::IDX_W-1:0]       lo;
		logic [lrast_pkg::IDX_W-1:0]       hi;
		logic [lrast_pkg::VAL_W-1:0]       leaf;
		logic [lrast_pkg::VAL_W-1:0]       addv;
		bit                                typed;
		logic [lrast_pkg::SUM_W-1:0]       exp_sum;
		bit                                exp_valid;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lrast_req_if req_ch ();
	lrast_rsp_if rsp_ch ();

	lazy_range_add_sum_tree_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#200_000_000;
		$display("timeout at %0t", $time);
		$display("Simulation FAILED");
		$finish;
	end

	// model tree state
	logic [lrast_pkg::SUM_W-1:0] tree_sum [lrast_pkg::NODES];
	logic [lrast_pkg::SUM_W-1:0] tree_pend [lrast_pkg::NODES];

	lrast_pkg::rsp_word_t expected_q [$];
	int errors = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int n_writes = 0, n_builds = 0, n_adds = 0, n_sums = 0, n_empty = 0;
	int n_checked = 0;

	function automatic void push_down(int unsigned n, int unsigned s, int unsigned e);
		logic [lrast_pkg::SUM_W-1:0] p;
		p = tree_pend[n];
		if (p == 0)
			return;
		tree_sum[n] = tree_sum[n] + p * 64'(e - s + 1);
		if (s != e) begin
			tree_pend[2*n]   = tree_pend[2*n] + p;
			tree_pend[2*n+1] = tree_pend[2*n+1] + p;
		end
		tree_pend[n] = '0;
	endfunction

	function automatic void rebuild(int unsigned n, int unsigned s, int unsigned e);
		int unsigned m;
		if (s == e)
			return;
		m = (s + e) / 2;
		rebuild(2*n, s, m);
		rebuild(2*n+1, m + 1, e);
		tree_sum[n] = tree_sum[2*n] + tree_sum[2*n+1];
	endfunction

	function automatic void range_add(int unsigned n, int unsigned s, int unsigned e,
			int unsigned lo, int unsigned hi, logic [lrast_pkg::SUM_W-1:0] v);
		int unsigned m;
		push_down(n, s, e);
		if (hi < s || e < lo)
			return;
		if (lo <= s && e <= hi) begin
			tree_pend[n] = tree_pend[n] + v;
			push_down(n, s, e);
			return;
		end
		m = (s + e) / 2;
		range_add(2*n, s, m, lo, hi, v);
		range_add(2*n+1, m + 1, e, lo, hi, v);
		push_down(2*n, s, m);
		push_down(2*n+1, m + 1, e);
		tree_sum[n] = tree_sum[2*n] + tree_sum[2*n+1];
	endfunction

	function automatic logic [lrast_pkg::SUM_W-1:0] range_total(int unsigned n,
			int unsigned s, int unsigned e, int unsigned lo, int unsigned hi);
		int unsigned m;
		push_down(n, s, e);
		if (hi < s || e < lo)
			return '0;
		if (lo <= s && e <= hi)
			return tree_sum[n];
		m = (s + e) / 2;
		return range_total(2*n, s, m, lo, hi) + range_total(2*n+1, m + 1, e, lo, hi);
	endfunction

	function automatic lrast_pkg::rsp_word_t tree_step(lrast_pkg::req_kind_t kind,
			int unsigned lo, int unsigned hi, logic [lrast_pkg::VAL_W-1:0] leaf,
			logic [lrast_pkg::VAL_W-1:0] addv);
		lrast_pkg::rsp_word_t r;
		int unsigned n, s, e, m;
		r.sum_value = '0;
		r.sum_valid = 1'b0;
		case (kind)
			lrast_pkg::REQ_WRITE: begin
				n = 1; s = 0; e = lrast_pkg::LEAVES - 1;
				while (s != e) begin
					m = (s + e) / 2;
					if (lo <= m) begin
						n = 2 * n; e = m;
					end else begin
						n = 2 * n + 1; s = m + 1;
					end
				end
				tree_sum[n] = {{32{leaf[31]}}, leaf};
			end
			lrast_pkg::REQ_BUILD: rebuild(1, 0, lrast_pkg::LEAVES - 1);
			lrast_pkg::REQ_ADD: begin
				if (lo <= hi)
					range_add(1, 0, lrast_pkg::LEAVES - 1, lo, hi, {{32{addv[31]}}, addv});
			end
			default: begin
				r.sum_valid = 1'b1;
				if (lo <= hi)
					r.sum_value = range_total(1, 0, lrast_pkg::LEAVES - 1, lo, hi);
			end
		endcase
		return r;
	endfunction

	task automatic send_word(lrast_pkg::req_kind_t kind, logic [lrast_pkg::IDX_W-1:0] lo,
			logic [lrast_pkg::IDX_W-1:0] hi, logic [lrast_pkg::VAL_W-1:0] leaf,
			logic [lrast_pkg::VAL_W-1:0] addv, bit typed,
			logic [lrast_pkg::SUM_W-1:0] t_sum, bit t_valid);
		lrast_pkg::rsp_word_t r;
		if ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= kind;
		req_ch.range_low  <= lo;
		req_ch.range_high <= hi;
		req_ch.leaf_value <= leaf;
		req_ch.add_value  <= addv;
		do @(posedge clk); while (!req_ch.ready);
		r = tree_step(kind, lo, hi, leaf, addv);
		if (typed) begin
			r.sum_value = t_sum;
			r.sum_valid = t_valid;
		end
		expected_q.push_back(r);
		case (kind)
			lrast_pkg::REQ_WRITE: n_writes++;
			lrast_pkg::REQ_BUILD: n_builds++;
			lrast_pkg::REQ_ADD:   n_adds++;
			default:              n_sums++;
		endcase
		if (kind inside {lrast_pkg::REQ_ADD, lrast_pkg::REQ_SUM} && lo > hi)
			n_empty++;
	endtask

	// response side
	always @(posedge clk) begin
		lrast_pkg::rsp_word_t exp_w;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected word sum=%0d valid=%0b", $time,
					rsp_ch.sum_value, rsp_ch.sum_valid);
				errors++;
			end else begin
				exp_w = expected_q.pop_front();
				n_checked++;
				if (rsp_ch.sum_value !== exp_w.sum_value) begin
					$display("%0t: sum_value expected %0d actual %0d", $time,
						exp_w.sum_value, rsp_ch.sum_value);
					errors++;
				end
				if (rsp_ch.sum_valid !== exp_w.sum_valid) begin
					$display("%0t: sum_valid expected %0b actual %0b", $time,
						exp_w.sum_valid, rsp_ch.sum_valid);
					errors++;
				end
			end
		end
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		dir_row_t rows [$];
		lrast_pkg::req_kind_t kind;
		logic [lrast_pkg::IDX_W-1:0] a, b;
		logic [lrast_pkg::VAL_W-1:0] v;
		int pick;
		int waited;

		for (int i = 0; i < lrast_pkg::NODES; i++) begin
			tree_sum[i] = '0;
			tree_pend[i] = '0;
		end
		req_ch.valid      <= 1'b0;
		req_ch.req_type   <= lrast_pkg::REQ_WRITE;
		req_ch.range_low  <= '0;
		req_ch.range_high <= '0;
		req_ch.leaf_value <= '0;
		req_ch.add_value  <= '0;

		rows = '{
			'{lrast_pkg::REQ_SUM,   10'd0,    10'd1023, 32'h0, 32'h0, 1, 64'd0, 1},
			'{lrast_pkg::REQ_WRITE, 10'd0,    10'd1023, 32'h80000000, 32'hffffffff, 1, 64'd0, 0},
			'{lrast_pkg::REQ_WRITE, 10'd1023, 10'd0,    32'h7fffffff, 32'h0, 1, 64'd0, 0},
			'{lrast_pkg::REQ_WRITE, 10'd5,    10'h3ff,  32'd1234, 32'h0, 1, 64'd0, 0},
			'{lrast_pkg::REQ_BUILD, 10'd0,    10'd0,    32'h0, 32'h0, 1, 64'd0, 0},
			'{lrast_pkg::REQ_SUM,   10'd0,    10'd1023, 32'h0, 32'h0, 0, 64'd0, 0},
			'{lrast_pkg::REQ_ADD,   10'd0,    10'd1023, 32'h0, 32'h80000000, 1, 64'd0, 0},
			'{lrast_pkg::REQ_ADD,   10'd1023, 10'd1023, 32'h0, 32'h7fffffff, 1, 64'd0, 0},
			'{lrast_pkg::REQ_SUM,   10'd1023, 10'd1023, 32'h0, 32'h0, 0, 64'd0, 0},
			'{lrast_pkg::REQ_ADD,   10'd7,    10'd3,    32'h0, 32'd99, 1, 64'd0, 0},
			'{lrast_pkg::REQ_SUM,   10'd9,    10'd2,    32'h0, 32'h0, 1, 64'd0, 1},
			'{lrast_pkg::REQ_SUM,   10'd1023, 10'd0,    32'h0, 32'h0, 1, 64'd0, 1},
			'{lrast_pkg::REQ_SUM,   10'd0,    10'd0,    32'h0, 32'h0, 0, 64'd0, 0},
			'{lrast_pkg::REQ_WRITE, 10'd3,    10'd0,    32'h55555555, 32'haaaaaaaa, 1, 64'd0, 0},
			'{lrast_pkg::REQ_SUM,   10'd3,    10'd3,    32'h0, 32'h0, 0, 64'd0, 0},
			'{lrast_pkg::REQ_BUILD, 10'd1023, 10'd1023, 32'hffffffff, 32'hffffffff, 1, 64'd0, 0},
			'{lrast_pkg::REQ_SUM,   10'd0,    10'd1023, 32'h0, 32'h0, 0, 64'd0, 0},
			'{lrast_pkg::REQ_ADD,   10'd100,  10'd600,  32'h0, 32'd77, 1, 64'd0, 0},
			'{lrast_pkg::REQ_SUM,   10'd50,   10'd700,  32'h0, 32'h0, 0, 64'd0, 0},
			'{lrast_pkg::REQ_WRITE, 10'd512,  10'd511,  32'haaaaaaaa, 32'h55555555, 1, 64'd0, 0},
			'{lrast_pkg::REQ_SUM,   10'd511,  10'd512,  32'h0, 32'h0, 0, 64'd0, 0},
			'{lrast_pkg::REQ_ADD,   10'd511,  10'd512,  32'h0, 32'hffffffff, 1, 64'd0, 0},
			'{lrast_pkg::REQ_SUM,   10'd0,    10'd1023, 32'h0, 32'h0, 0, 64'd0, 0},
			'{lrast_pkg::REQ_SUM,   10'd1,    10'd1022, 32'h0, 32'h0, 0, 64'd0, 0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_word(rows[i].kind, rows[i].lo, rows[i].hi, rows[i].leaf, rows[i].addv,
				rows[i].typed, rows[i].exp_sum, rows[i].exp_valid);

		for (int i = 0; i < N_RANDOM; i++) begin
			case (i * 4 / N_RANDOM)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 67; end
				default: begin sender_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			pick = $urandom_range(99);
			kind = pick < 25 ? lrast_pkg::REQ_WRITE : pick < 28 ? lrast_pkg::REQ_BUILD :
				pick < 63 ? lrast_pkg::REQ_ADD : lrast_pkg::REQ_SUM;
			a = lrast_pkg::IDX_W'($urandom);
			b = lrast_pkg::IDX_W'($urandom);
			pick = $urandom_range(99);
			if (pick < 8) begin
				a = '0;
				b = lrast_pkg::IDX_W'(lrast_pkg::LEAVES - 1);
			end else if (pick < 16) begin
				b = a;
			end else if (pick < 24) begin
				if (a == b) a = a + 1'b1;
				if (a < b) {a, b} = {b, a};
			end else if (a > b) begin
				{a, b} = {b, a};
			end
			pick = $urandom_range(9);
			v = pick == 0 ? 32'h80000000 : pick == 1 ? 32'h7fffffff :
				pick < 5 ? 32'($signed($urandom_range(200)) - 100) : 32'($urandom);
			send_word(kind, a, b, v, kind == lrast_pkg::REQ_ADD ? v : 32'($urandom),
				0, '0, 0);
		end
		req_ch.valid <= 1'b0;

		waited = 0;
		while (expected_q.size() != 0 && waited < 2_000_000) begin
			@(posedge clk);
			waited++;
		end
		repeat (300) @(posedge clk);
		if (expected_q.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, expected_q.size());
			errors++;
		end

		$display("covered %0d writes, %0d builds, %0d adds, %0d sums (%0d empty ranges)",
			n_writes, n_builds, n_adds, n_sums, n_empty);
		$display("%0d result words checked, %0d mismatches", n_checked, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
